FILE: src/i2cm_pkg.sv
// Shared types, codes and register defaults for the I2C master bit sequencer.
package i2cm_pkg;

    localparam int TICK_COUNTER_WIDTH_DEF = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
    localparam logic [15:0] READ_LOW_RESET    = 16'd30;
    localparam logic [7:0]  ACK_POLLS_RESET   = 8'd250;

    localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_READ_LOW    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACK_POLLS   = 2'd2;

    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_ACK   = 3'd4;
    localparam logic [2:0] MODE_READ  = 3'd5;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_ST1       = 4'd1;
    localparam logic [3:0] PH_ST2       = 4'd2;
    localparam logic [3:0] PH_SP1       = 4'd3;
    localparam logic [3:0] PH_SP2       = 4'd4;
    localparam logic [3:0] PH_SP3       = 4'd5;
    localparam logic [3:0] PH_WR_DATA   = 4'd6;
    localparam logic [3:0] PH_WR_HIGH   = 4'd7;
    localparam logic [3:0] PH_WR_LOW    = 4'd8;
    localparam logic [3:0] PH_ACK_POLL  = 4'd9;
    localparam logic [3:0] PH_RD_LOW    = 4'd10;
    localparam logic [3:0] PH_RD_SAMPLE = 4'd11;
    localparam logic [3:0] PH_RA_LOW    = 4'd12;
    localparam logic [3:0] PH_RA_HIGH   = 4'd13;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_sample;
    } in_word_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } out_word_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [15:0] read_low_ticks;
        logic [7:0]  ack_timeout_polls;
    } cfg_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] bit_index;
        logic [7:0] shift;
        logic [7:0] poll;
        logic       ack_choice;
        logic       scl;
        logic       sda;
        logic       drive;
        logic [7:0] rx_byte;
        logic       ack_fail;
    } seq_state_t;

endpackage

FILE: src/i2c_master_bit_sequencer_top.sv
// Top level of the I2C master bit sequencer: state, result register and handshakes.
//
// Each input word is one bus tick and yields exactly one result word. A tick is
// taken in every clock cycle as long as the result register is empty or is being
// read in the same cycle, so the sustained rate is one word per cycle; the only
// loop is the sequencer state and tick counter feeding their own next-state logic,
// and a result appears in the cycle after its tick is accepted. The user must
// write registers through the plain write port while no tick is in flight; the
// block itself does not enforce this. No clearing pass is needed after reset.
module i2c_master_bit_sequencer_top
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = TICK_COUNTER_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data
);

    localparam int W = TICK_COUNTER_WIDTH;

    cfg_t       cfg;
    seq_state_t st_reg;
    seq_state_t st_next;
    logic [W-1:0] cnt_reg;
    logic [W-1:0] cnt_next;
    logic       done;
    logic       accept;
    logic       m_valid_reg;
    out_word_t  m_data_reg;
    out_word_t  m_data_next;

    i2cm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    i2cm_step #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_step (
        .cfg      (cfg),
        .in_word  (s_data),
        .st       (st_reg),
        .cnt      (cnt_reg),
        .st_next  (st_next),
        .cnt_next (cnt_next),
        .done     (done)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_data_next.scl_level  = st_next.scl;
        m_data_next.sda_level  = st_next.sda;
        m_data_next.sda_drive  = st_next.drive;
        m_data_next.busy_res   = (st_next.phase != PH_IDLE);
        m_data_next.done_res   = done;
        m_data_next.rx_byte    = st_next.rx_byte;
        m_data_next.ack_failed = st_next.ack_fail;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase      <= PH_IDLE;
            st_reg.bit_index  <= '0;
            st_reg.shift      <= '0;
            st_reg.poll       <= '0;
            st_reg.ack_choice <= 1'b0;
            st_reg.scl        <= 1'b1;
            st_reg.sda        <= 1'b1;
            st_reg.drive      <= 1'b1;
            st_reg.rx_byte    <= '0;
            st_reg.ack_fail   <= 1'b0;
            cnt_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (accept) begin
                st_reg      <= st_next;
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    property p_idle_cnt_zero;
        @(posedge aclk) disable iff (!aresetn)
        (st_reg.phase == PH_IDLE) |-> (cnt_reg == '0);
    endproperty
    a_idle_cnt_zero: assert property (p_idle_cnt_zero)
        else $error("tick counter not cleared while idle");

    property p_done_not_busy;
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.done_res && m_data.busy_res);
    endproperty
    a_done_not_busy: assert property (p_done_not_busy)
        else $error("done reported while still busy");

    property p_release_high;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.sda_drive) |-> m_data.sda_level;
    endproperty
    a_release_high: assert property (p_release_high)
        else $error("released SDA not reported high");

    property p_start_first_tick;
        @(posedge aclk) disable iff (!aresetn)
        (accept && st_reg.phase == PH_IDLE && s_data.mode == MODE_START)
            |=> (m_valid && m_data.scl_level && m_data.sda_level && m_data.busy_res);
    endproperty
    a_start_first_tick: assert property (p_start_first_tick)
        else $error("start tick did not hold both lines high");

endmodule

FILE: src/i2cm_cfg.sv
// Configuration registers of the I2C master bit sequencer.
module i2cm_cfg
    import i2cm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.half_period_ticks <= HALF_PERIOD_RESET;
            cfg_reg.read_low_ticks    <= READ_LOW_RESET;
            cfg_reg.ack_timeout_polls <= ACK_POLLS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_wdata;
                REG_READ_LOW:    cfg_reg.read_low_ticks    <= cfg_wdata;
                REG_ACK_POLLS:   cfg_reg.ack_timeout_polls <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/i2cm_step.sv
// Next-state logic of the I2C master bit sequencer for one tick.
module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = TICK_COUNTER_WIDTH_DEF
) (
    input  cfg_t                          cfg,
    input  in_word_t                      in_word,
    input  seq_state_t                    st,
    input  logic [TICK_COUNTER_WIDTH-1:0] cnt,
    output seq_state_t                    st_next,
    output logic [TICK_COUNTER_WIDTH-1:0] cnt_next,
    output logic                          done
);

    localparam int W  = TICK_COUNTER_WIDTH;
    localparam int LW = (W > 16) ? W : 16;

    logic [15:0]   dur;
    logic [LW-1:0] dur_ext;
    logic [LW-1:0] cnt_max;
    logic [LW-1:0] lim_nz;
    logic [LW-1:0] lim_ext;
    logic [W-1:0]  lim;
    logic [W-1:0]  cnt_inc;
    logic          elapsed;
    logic [7:0]    rd_shift;

    always_comb begin
        dur      = (st.phase == PH_RD_LOW) ? cfg.read_low_ticks : cfg.half_period_ticks;
        dur_ext  = LW'(dur);
        cnt_max  = LW'({W{1'b1}});
        lim_nz   = (dur == 16'd0) ? LW'(1) : dur_ext;
        lim_ext  = (lim_nz > cnt_max) ? cnt_max : lim_nz;
        lim      = lim_ext[W-1:0];
        cnt_inc  = (cnt != {W{1'b1}}) ? cnt + W'(1) : cnt;
        elapsed  = (cnt_inc >= lim);
        rd_shift = {st.shift[6:0], in_word.sda_sample};
    end

    always_comb begin
        st_next  = st;
        cnt_next = cnt;
        done     = 1'b0;
        unique case (st.phase)
            PH_IDLE: begin
                unique case (in_word.mode)
                    MODE_START: begin
                        st_next.drive = 1'b1;
                        st_next.sda   = 1'b1;
                        st_next.scl   = 1'b1;
                        st_next.phase = PH_ST1;
                        cnt_next      = '0;
                    end
                    MODE_STOP: begin
                        st_next.drive = 1'b1;
                        st_next.scl   = 1'b0;
                        st_next.sda   = 1'b0;
                        st_next.phase = PH_SP1;
                        cnt_next      = '0;
                    end
                    MODE_WRITE: begin
                        st_next.drive     = 1'b1;
                        st_next.scl       = 1'b0;
                        st_next.sda       = in_word.tx_byte[7];
                        st_next.shift     = {in_word.tx_byte[6:0], 1'b0};
                        st_next.bit_index = '0;
                        st_next.phase     = PH_WR_DATA;
                        cnt_next          = '0;
                    end
                    MODE_ACK: begin
                        st_next.drive = 1'b0;
                        st_next.sda   = 1'b1;
                        st_next.scl   = 1'b1;
                        st_next.poll  = '0;
                        st_next.phase = PH_ACK_POLL;
                        cnt_next      = '0;
                    end
                    MODE_READ: begin
                        st_next.drive      = 1'b0;
                        st_next.sda        = 1'b1;
                        st_next.scl        = 1'b0;
                        st_next.bit_index  = '0;
                        st_next.shift      = '0;
                        st_next.ack_choice = in_word.send_ack;
                        st_next.phase      = PH_RD_LOW;
                        cnt_next           = '0;
                    end
                    default: begin
                    end
                endcase
            end
            PH_ST1: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.sda   = 1'b0;
                    st_next.phase = PH_ST2;
                end
            end
            PH_ST2: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.scl   = 1'b0;
                    st_next.phase = PH_IDLE;
                    done          = 1'b1;
                end
            end
            PH_SP1: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_SP2;
                end
            end
            PH_SP2: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.sda   = 1'b1;
                    st_next.phase = PH_SP3;
                end
            end
            PH_SP3: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.phase = PH_IDLE;
                    done          = 1'b1;
                end
            end
            PH_WR_DATA: begin
                st_next.scl   = 1'b1;
                st_next.phase = PH_WR_HIGH;
                cnt_next      = '0;
            end
            PH_WR_HIGH: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.scl   = 1'b0;
                    st_next.phase = PH_WR_LOW;
                end
            end
            PH_WR_LOW: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    if (st.bit_index == 3'd7) begin
                        st_next.phase = PH_IDLE;
                        done          = 1'b1;
                    end else begin
                        st_next.bit_index = st.bit_index + 3'd1;
                        st_next.sda       = st.shift[7];
                        st_next.shift     = {st.shift[6:0], 1'b0};
                        st_next.phase     = PH_WR_DATA;
                    end
                end
            end
            PH_ACK_POLL: begin
                if (!in_word.sda_sample) begin
                    st_next.scl      = 1'b0;
                    st_next.ack_fail = 1'b0;
                    st_next.phase    = PH_IDLE;
                    cnt_next         = '0;
                    done             = 1'b1;
                end else if (st.poll >= cfg.ack_timeout_polls) begin
                    st_next.ack_fail = 1'b1;
                    st_next.drive    = 1'b1;
                    st_next.scl      = 1'b0;
                    st_next.sda      = 1'b0;
                    st_next.phase    = PH_SP1;
                    cnt_next         = '0;
                end else begin
                    st_next.poll = st.poll + 8'd1;
                end
            end
            PH_RD_LOW: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_RD_SAMPLE;
                end
            end
            PH_RD_SAMPLE: begin
                st_next.shift = rd_shift;
                st_next.scl   = 1'b0;
                cnt_next      = '0;
                if (st.bit_index == 3'd7) begin
                    st_next.rx_byte = rd_shift;
                    st_next.drive   = 1'b1;
                    st_next.sda     = !st.ack_choice;
                    st_next.phase   = PH_RA_LOW;
                end else begin
                    st_next.bit_index = st.bit_index + 3'd1;
                    st_next.phase     = PH_RD_LOW;
                end
            end
            PH_RA_LOW: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_RA_HIGH;
                end
            end
            PH_RA_HIGH: begin
                cnt_next = elapsed ? '0 : cnt_inc;
                if (elapsed) begin
                    st_next.scl   = 1'b0;
                    st_next.phase = PH_IDLE;
                    done          = 1'b1;
                end
            end
            default: begin
                st_next.phase = PH_IDLE;
                cnt_next      = '0;
            end
        endcase
    end

endmodule
